// ===== rtl/coma_pkg.sv =====
// package for the cell owner map allocator
// holds sizes, codes and shared types; used by every module in rtl
`timescale 1ns / 1ps

package coma_pkg;

   localparam int NUM_CELLS = 1024;
   localparam int ID_BITS   = 8;

   localparam int ADDR_W = $clog2(NUM_CELLS);
   localparam int CNT_W  = $clog2(NUM_CELLS + 1);

   // fixed widths of the stream fields
   localparam int SIZE_W  = 11;
   localparam int OWNER_W = 8;
   localparam int CMP_W   = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;

   localparam int REQ_DATA_W = ((SIZE_W + OWNER_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((OWNER_W + 2 * SIZE_W + 7) / 8) * 8;

   localparam logic REQ_CREATE    = 1'b0;
   localparam logic REQ_TERMINATE = 1'b1;

   localparam logic RSP_DONE    = 1'b0;
   localparam logic RSP_REFUSED = 1'b1;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ID_BITS-1:0] id_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [OWNER_W-1:0] owner_type;
   typedef logic [CMP_W-1:0]   cmp_type;

   typedef struct packed {
      logic   used;
      id_type owner;
   } entry_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type entry;
   } wr_type;

   typedef struct packed {
      logic      status;
      owner_type result_id;
      size_type  cells_changed;
      size_type  free_cells;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

// ===== rtl/cell_owner_map_allocator.sv =====
// cell owner map allocator, top level: sequencer, map memory, output register
// depends on coma_pkg, coma_map_ram and coma_scan_ctrl
`timescale 1ns / 1ps

// usage
//   req channel: one word per request. tuser is the kind (create or
//   terminate), tdata carries the size and the owner id
//   rsp channel: one word per request. tuser is the status (done or
//   refused), tdata carries the id, the cells changed and the free count
//   scan: a create or terminate scans every cell of the owner map, one
//   cell a cycle through the memory's single read port; a refused create
//   skips the scan and goes straight to its result. one request is worked
//   on at a time, so no request is taken until the last one's result has
//   left the sequencer
//   reset: the map is swept to all free with req_tready low; free count
//   returns to NUM_CELLS and next id to 0
//   stall: the result sits in an output register; the next request is taken
//   while it waits, but its own result holds in the sequencer until the
//   register frees up
module cell_owner_map_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [coma_pkg::REQ_DATA_W-1:0]     req_tdata,  // alloc_size, owner_id, zero pad
   input  logic                                req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [coma_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // result_id, cells_changed, free_cells, zero pad
   output logic                                rsp_tuser   // status
);

   logic                rd_en;
   coma_pkg::addr_type  rd_addr;
   coma_pkg::entry_type rd_data;
   coma_pkg::wr_type    wr;
   logic                res_valid;
   logic                res_ready;
   coma_pkg::rsp_type   res;

   logic                out_valid_ff, out_valid_in;
   coma_pkg::rsp_type   out_data_ff, out_data_in;

   coma_scan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_size  (req_tdata[coma_pkg::SIZE_W-1:0]),
      .req_owner (req_tdata[coma_pkg::SIZE_W +: coma_pkg::OWNER_W]),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr        (wr),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   coma_map_ram u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_data (rd_data)
   );

   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (res_ready) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.status;
   assign rsp_tdata  = {
      {(coma_pkg::RSP_DATA_W - coma_pkg::OWNER_W - 2 * coma_pkg::SIZE_W){1'b0}},
      out_data_ff.free_cells,
      out_data_ff.cells_changed,
      out_data_ff.result_id
   };

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in progress");

   // refused create changes nothing
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == coma_pkg::RSP_REFUSED) |->
      (out_data_ff.cells_changed == '0 && out_data_ff.result_id == '0))
      else $error("refused create reports cells or an id");

   // free count never above the map size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
      (coma_pkg::cmp_type'(out_data_ff.free_cells) <=
       coma_pkg::cmp_type'(coma_pkg::NUM_CELLS)))
      else $error("free count above map size");

endmodule

// ===== rtl/coma_map_ram.sv =====
// owner map storage: one entry per cell, one write and one read port
// read data registered; uses coma_pkg
`timescale 1ns / 1ps

module coma_map_ram (
   input  logic                clock,
   input  logic                rd_en,
   input  coma_pkg::addr_type  rd_addr,
   input  coma_pkg::wr_type    wr,
   output coma_pkg::entry_type rd_data
);

   coma_pkg::entry_type mem [coma_pkg::NUM_CELLS];
   coma_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/coma_scan_ctrl.sv =====
// request sequencer: clearing pass, map scan with read-modify-write,
// free count and next id; uses coma_pkg, drives coma_map_ram
`timescale 1ns / 1ps

module coma_scan_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  coma_pkg::size_type    req_size,
   input  coma_pkg::owner_type   req_owner,
   output logic                  rd_en,
   output coma_pkg::addr_type    rd_addr,
   input  coma_pkg::entry_type   rd_data,
   output coma_pkg::wr_type      wr,
   output logic                  res_valid,
   input  logic                  res_ready,
   output coma_pkg::rsp_type     res
);

   coma_pkg::state_type state_ff, state_in;
   coma_pkg::cnt_type   cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   coma_pkg::id_type    next_id_ff, next_id_in;
   coma_pkg::cnt_type   free_ff, free_in;
   coma_pkg::cnt_type   changed_ff, changed_in;

   coma_pkg::addr_type  pend_addr_ff, pend_addr_in;
   logic                kind_ff, kind_in;
   coma_pkg::cnt_type   size_ff, size_in;
   coma_pkg::id_type    id_out_ff, id_out_in;
   logic                status_ff, status_in;

   logic                hit;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      next_id_in   = next_id_ff;
      free_in      = free_ff;
      changed_in   = changed_ff;
      pend_addr_in = pend_addr_ff;
      kind_in      = kind_ff;
      size_in      = size_ff;
      id_out_in    = id_out_ff;
      status_in    = status_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff[coma_pkg::ADDR_W-1:0];
      wr           = '0;
      res_valid    = 1'b0;
      hit          = 1'b0;

      case (state_ff)
         coma_pkg::ST_CLEAR: begin
            wr.en    = 1'b1;
            wr.addr  = cnt_ff[coma_pkg::ADDR_W-1:0];
            wr.entry = '0;
            if (cnt_ff == coma_pkg::cnt_type'(coma_pkg::NUM_CELLS - 1)) begin
               cnt_in   = '0;
               state_in = coma_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         coma_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in    = req_kind;
               cnt_in     = '0;
               pend_in    = 1'b0;
               changed_in = '0;
               status_in  = coma_pkg::RSP_DONE;
               if (req_kind == coma_pkg::REQ_CREATE) begin
                  if (coma_pkg::cmp_type'(req_size) > coma_pkg::cmp_type'(free_ff)) begin
                     status_in = coma_pkg::RSP_REFUSED;
                     id_out_in = '0;
                     state_in  = coma_pkg::ST_DONE;
                  end else begin
                     id_out_in  = next_id_ff;
                     next_id_in = next_id_ff + 1'b1;
                     size_in    = coma_pkg::cnt_type'(req_size);
                     state_in   = coma_pkg::ST_SCAN;
                  end
               end else begin
                  id_out_in = coma_pkg::id_type'(req_owner);
                  state_in  = coma_pkg::ST_SCAN;
               end
            end
         end
         coma_pkg::ST_SCAN: begin
            // issue stage
            if (cnt_ff != coma_pkg::cnt_type'(coma_pkg::NUM_CELLS)) begin
               rd_en        = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff[coma_pkg::ADDR_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            // modify and write back stage
            if (pend_ff) begin
               if (kind_ff == coma_pkg::REQ_CREATE) begin
                  hit            = !rd_data.used && (changed_ff < size_ff);
                  wr.entry.used  = 1'b1;
                  wr.entry.owner = id_out_ff;
               end else begin
                  hit      = rd_data.used && (rd_data.owner == id_out_ff);
                  wr.entry = '0;
               end
               wr.en   = hit;
               wr.addr = pend_addr_ff;
               if (hit) begin
                  changed_in = changed_ff + 1'b1;
                  if (kind_ff == coma_pkg::REQ_CREATE) begin
                     free_in = free_ff - 1'b1;
                  end else begin
                     free_in = free_ff + 1'b1;
                  end
               end
            end
            if (cnt_ff == coma_pkg::cnt_type'(coma_pkg::NUM_CELLS) && !pend_ff) begin
               state_in = coma_pkg::ST_DONE;
            end
         end
         coma_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = coma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = coma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= coma_pkg::ST_CLEAR;
         cnt_ff     <= '0;
         pend_ff    <= 1'b0;
         next_id_ff <= '0;
         free_ff    <= coma_pkg::cnt_type'(coma_pkg::NUM_CELLS);
         changed_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pend_ff    <= pend_in;
         next_id_ff <= next_id_in;
         free_ff    <= free_in;
         changed_ff <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      kind_ff      <= kind_in;
      size_ff      <= size_in;
      id_out_ff    <= id_out_in;
      status_ff    <= status_in;
   end

   assign res.status        = status_ff;
   assign res.result_id     = coma_pkg::owner_type'(id_out_ff);
   assign res.cells_changed = coma_pkg::size_type'(changed_ff);
   assign res.free_cells    = coma_pkg::size_type'(free_ff);

endmodule

// ===== test/tb_cell_owner_map_allocator.sv =====
// testbench for cell_owner_map_allocator: directed and random create and terminate words,
// checked field by field against an owner map kept here; depends on coma_pkg and the rtl
`timescale 1ns / 1ps

module tb_cell_owner_map_allocator;
   import coma_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int STALL_CYCLES = 3000;
   localparam int DRAIN_TAIL   = 1100;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // owner map as the block should hold it
   logic     cell_taken [NUM_CELLS];
   id_type   cell_holder[NUM_CELLS];
   int       free_total;
   id_type   id_next;

   rsp_type  pending_outcomes[$];
   int       error_count;
   int       cycle_count;
   bit       quiet;
   int       stall_orders;
   int       stall_served;
   int       stall_left;

   cell_owner_map_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic rsp_type allocate_or_free(logic kind, size_type size, owner_type owner);
      rsp_type outcome;
      int      changed;
      id_type  who;
      outcome = '0;
      changed = 0;
      who     = owner[ID_BITS-1:0];
      if (kind == REQ_CREATE) begin
         if (size > free_total) begin
            outcome.status = RSP_REFUSED;
         end else begin
            outcome.status    = RSP_DONE;
            outcome.result_id = owner_type'(id_next);
            // lowest free cells first
            for (int i = 0; i < NUM_CELLS && changed < size; i++) begin
               if (!cell_taken[i]) begin
                  cell_taken[i]  = 1'b1;
                  cell_holder[i] = id_next;
                  changed++;
               end
            end
            id_next    = id_next + 1'b1;
            free_total = free_total - changed;
         end
      end else begin
         for (int i = 0; i < NUM_CELLS; i++) begin
            if (cell_taken[i] && cell_holder[i] == who) begin
               cell_taken[i]  = 1'b0;
               cell_holder[i] = '0;
               changed++;
            end
         end
         free_total        = free_total + changed;
         outcome.status    = RSP_DONE;
         outcome.result_id = owner_type'(who);
      end
      outcome.cells_changed = size_type'(changed);
      outcome.free_cells    = size_type'(free_total);
      return outcome;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // result sink: checks each word and drives rsp_tready
   always @(posedge clock) begin : rsp_sink
      rsp_type predicted;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result word with nothing expected");
               error_count++;
            end else begin
               predicted = pending_outcomes.pop_front();
               check_field("status", predicted.status, rsp_tuser);
               check_field("result_id", predicted.result_id, rsp_tdata[OWNER_W-1:0]);
               check_field("cells_changed", predicted.cells_changed,
                           rsp_tdata[OWNER_W +: SIZE_W]);
               check_field("free_cells", predicted.free_cells,
                           rsp_tdata[OWNER_W + SIZE_W +: SIZE_W]);
            end
         end
         if (stall_served != stall_orders) begin
            stall_served = stall_orders;
            stall_left   = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 7);
         end
      end
   end

   task automatic send_request(logic kind, size_type size, owner_type owner);
      while (!quiet && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'({owner, size});
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(allocate_or_free(kind, size, owner));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic create(size_type size);
      send_request(REQ_CREATE, size, owner_type'($urandom));
   endtask

   task automatic terminate(owner_type owner);
      send_request(REQ_TERMINATE, size_type'($urandom), owner);
   endtask

   task automatic random_request();
      int        pick;
      int        idx;
      size_type  size;
      owner_type owner;
      if ($urandom_range(99) < 62) begin
         pick = $urandom_range(99);
         if (pick < 5)       size = '0;
         else if (pick < 72) size = size_type'($urandom_range(40, 1));
         else if (pick < 88) size = size_type'($urandom_range(300, 41));
         else if (pick < 92) size = size_type'($urandom_range(NUM_CELLS, 301));
         else if (pick < 96) size = size_type'(free_total);
         else                size = size_type'($urandom_range(2047, NUM_CELLS + 1));
         create(size);
      end else begin
         owner = owner_type'($urandom_range(255));
         // mostly an owner that holds cells
         if (free_total < NUM_CELLS && $urandom_range(99) < 85) begin
            idx = $urandom_range(NUM_CELLS - 1);
            while (!cell_taken[idx]) idx = (idx + 1) % NUM_CELLS;
            owner = owner_type'(cell_holder[idx]);
         end
         terminate(owner);
      end
   endtask

   task automatic test_directed();
      create(0);
      create(size_type'(NUM_CELLS));
      create(1);
      create(2047);
      create(0);
      terminate(1);
      terminate(255);
      terminate(0);
      create(5);
      create(3);
      create(7);
      terminate(4);
      create(10);
      create(1003);
      create(1002);
      terminate(3);
      terminate(5);
      terminate(6);
      terminate(7);
      wait_for_results();
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) random_request();
   endtask

   task automatic test_steady_stream();
      quiet = 1'b1;
      test_random_traffic(120);
      wait_for_results();
      quiet = 1'b0;
   endtask

   task automatic test_receiver_stall();
      stall_orders++;
      test_random_traffic(8);
      wait_for_results();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_CREATE;
      quiet      = 1'b0;
      free_total = NUM_CELLS;
      id_next    = '0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         cell_taken[i]  = 1'b0;
         cell_holder[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(250);
      wait_for_results();
      test_steady_stream();
      test_receiver_stall();
      test_random_traffic(180);
      wait_for_results();

      repeat (DRAIN_TAIL) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
